FILE: hw/rtl/trpd_pkg.sv
// Shared types, register indexes and colour conversion for the TGA RLE pixel decoder.
package trpd_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 19;

    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_TOTAL     = 2'd1;

    localparam logic [2:0]  BPP_RESET   = 3'd2;
    localparam logic [18:0] TOTAL_RESET = 19'd262144;

    localparam logic [2:0] BPP_INDEX  = 3'd1;
    localparam logic [2:0] BPP_BGR16  = 3'd2;
    localparam logic [2:0] BPP_BGR24  = 3'd3;
    localparam logic [2:0] BPP_BGRA32 = 3'd4;

    localparam logic [15:0] COLOR_OPAQUE = 16'h8000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       image_start;
    } t_in_item;

    typedef struct packed {
        logic [15:0] color;
        logic [7:0]  run_length;
        logic        image_end;
    } t_out_item;

    // Little-endian pixel bytes to RGB555, bit 15 set; an index byte passes as is.
    function automatic logic [15:0] pixel_color(input logic [2:0] bpp,
                                                input logic [31:0] bytes);
        logic [15:0] c;
        c = COLOR_OPAQUE;
        unique case (bpp)
            BPP_INDEX: c = {8'd0, bytes[7:0]};
            BPP_BGR16: c = {1'b1, bytes[4:0], bytes[9:5], bytes[14:10]};
            BPP_BGR24: c = {1'b1, bytes[7:3], bytes[15:11], bytes[23:19]};
            default: begin
                if (bytes[31:24] == 8'd0) begin
                    c = COLOR_OPAQUE;
                end else begin
                    c = {1'b1, bytes[7:3], bytes[15:11], bytes[23:19]};
                end
            end
        endcase
        return c;
    endfunction

endpackage

FILE: hw/rtl/tga_rle_pixel_decoder.sv
// Top level of the TGA RLE pixel decoder: byte stream in, RGB555 runs out.
// Usage
//   Input channel: one request per byte of run-length coded pixel data, with
//   image_start high on the first packet header byte of each image. A request
//   is taken at a rising edge with i_valid high and o_stall low.
//   Output channel: one request per finished pixel, carrying its colour, its
//   run length (repeat count or 1, clipped to the pixels left in the image)
//   and an image_end flag on the run that completes the image. A request is
//   taken at a rising edge with o_valid high and i_stall low.
//   Configuration: write bytes_per_pixel (index 0) and pixel_total (index 1)
//   through i_cfg_we / i_cfg_index / i_cfg_data while no request is in flight.
// Timing
//   One byte per cycle unless a full result register is stalled. The packet
//   state update and the colour conversion sit between the input port and a
//   single result register, so the result of the last byte of a pixel shows
//   in the cycle after that byte. Header and partial-pixel bytes give none.
// Reset and stall
//   Synchronous active-low reset clears the packet state, empties the result
//   register and restores bytes_per_pixel 2 and pixel_total 262144.
//   While the receiver stalls a full result register, o_stall rises and new
//   bytes are held off; an empty result register never stalls the input.
module tga_rle_pixel_decoder #(
    parameter int MAX_PIXELS = 262144
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  trpd_pkg::t_in_item                  i_data,
    output logic                                o_valid,
    input  logic                                i_stall,
    output trpd_pkg::t_out_item                 o_data,
    input  logic                                i_cfg_we,
    input  logic [trpd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [trpd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import trpd_pkg::*;

    // Pixel counter wide enough for the largest image; arithmetic widths
    // cover both the counter and the 19-bit register / 8-bit run.
    localparam int CNT_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS + 1) : 1;
    localparam int TOT_W = (CNT_W > CFG_DATA_W) ? CNT_W : CFG_DATA_W;
    localparam int SUM_W = (CNT_W > 8) ? CNT_W : 8;

    // Configuration registers
    logic [2:0]            r_bpp;
    logic [CFG_DATA_W-1:0] r_pixel_total;

    // Packet state
    logic             r_expect_header, n_expect_header;
    logic             r_repeat,        n_repeat;
    logic [7:0]       r_left,          n_left;
    logic [1:0]       r_bpos,          n_bpos;
    logic [23:0]      r_gather,        n_gather;
    logic [CNT_W-1:0] r_done,          n_done;
    logic             r_finished,      n_finished;

    // Result register
    logic      r_out_valid, n_out_valid;
    t_out_item r_out,       n_out;

    // Start-of-image view of the state
    logic             s_expect_header;
    logic             s_repeat;
    logic [7:0]       s_left;
    logic [1:0]       s_bpos;
    logic [23:0]      s_gather;
    logic [CNT_W-1:0] s_done;
    logic             s_finished;

    logic [2:0]       bpp_eff;
    logic [TOT_W-1:0] total_ext;
    logic [CNT_W-1:0] total_eff;
    logic             in_accept;
    logic             active;
    logic             emit;
    logic [7:0]       byte_in;
    logic [31:0]      pixel_bytes;
    logic [7:0]       run;
    logic [SUM_W-1:0] remaining;
    logic [SUM_W-1:0] run_clip;
    logic             run_end;

    assign o_stall   = r_out_valid && i_stall;
    assign in_accept = i_valid && !o_stall;
    assign o_valid   = r_out_valid;
    assign o_data    = r_out;
    assign byte_in   = i_data.data_byte;

    // Fold out-of-range register values: 0 reads as 1, 5..7 as 4.
    always_comb begin
        priority if (r_bpp == 3'd0) begin
            bpp_eff = BPP_INDEX;
        end else if (r_bpp > BPP_BGRA32) begin
            bpp_eff = BPP_BGRA32;
        end else begin
            bpp_eff = r_bpp;
        end
    end

    // Saturate the pixel total to the largest image.
    always_comb begin
        total_ext = TOT_W'(r_pixel_total);
        if (total_ext > TOT_W'(MAX_PIXELS)) begin
            total_eff = CNT_W'(MAX_PIXELS);
        end else begin
            total_eff = total_ext[CNT_W-1:0];
        end
    end

    // image_start restarts the counters before this byte is used.
    always_comb begin
        if (i_data.image_start) begin
            s_expect_header = 1'b1;
            s_repeat        = 1'b0;
            s_left          = 8'd0;
            s_bpos          = 2'd0;
            s_gather        = 24'd0;
            s_done          = '0;
            s_finished      = 1'b0;
        end else begin
            s_expect_header = r_expect_header;
            s_repeat        = r_repeat;
            s_left          = r_left;
            s_bpos          = r_bpos;
            s_gather        = r_gather;
            s_done          = r_done;
            s_finished      = r_finished;
        end
    end

    assign active = !s_finished && (s_done < total_eff);

    // Packet state update and result formation for one byte.
    always_comb begin
        n_expect_header = r_expect_header;
        n_repeat        = r_repeat;
        n_left          = r_left;
        n_bpos          = r_bpos;
        n_gather        = r_gather;
        n_done          = r_done;
        n_finished      = r_finished;
        emit            = 1'b0;
        pixel_bytes     = {8'd0, s_gather};
        run             = 8'd1;
        remaining       = SUM_W'(total_eff) - SUM_W'(s_done);
        run_clip        = '0;
        run_end         = 1'b0;

        // Assemble the final byte into its slot.
        unique case (bpp_eff)
            BPP_INDEX:  pixel_bytes[7:0]   = pixel_bytes[7:0]   | byte_in;
            BPP_BGR16:  pixel_bytes[15:8]  = pixel_bytes[15:8]  | byte_in;
            BPP_BGR24:  pixel_bytes[23:16] = pixel_bytes[23:16] | byte_in;
            default:    pixel_bytes[31:24] = pixel_bytes[31:24] | byte_in;
        endcase

        if (s_repeat) begin
            run = s_left;
        end
        if (run == 8'd0) begin
            run = 8'd1;
        end
        if (SUM_W'(run) > remaining) begin
            run_clip = remaining;
        end else begin
            run_clip = SUM_W'(run);
        end
        run_end = (run_clip == remaining);

        if (in_accept) begin
            n_expect_header = s_expect_header;
            n_repeat        = s_repeat;
            n_left          = s_left;
            n_bpos          = s_bpos;
            n_gather        = s_gather;
            n_done          = s_done;
            n_finished      = s_finished;
            if (active) begin
                priority if (s_expect_header) begin
                    n_repeat        = byte_in[7];
                    n_left          = {1'b0, byte_in[6:0]} + 8'd1;
                    n_bpos          = 2'd0;
                    n_gather        = 24'd0;
                    n_expect_header = 1'b0;
                end else if (({1'b0, s_bpos} + 3'd1) < bpp_eff) begin
                    unique case (s_bpos)
                        2'd0:    n_gather[7:0]   = s_gather[7:0]   | byte_in;
                        2'd1:    n_gather[15:8]  = s_gather[15:8]  | byte_in;
                        2'd2:    n_gather[23:16] = s_gather[23:16] | byte_in;
                        default: n_gather        = s_gather;
                    endcase
                    n_bpos = s_bpos + 2'd1;
                end else begin
                    emit     = 1'b1;
                    n_bpos   = 2'd0;
                    n_gather = 24'd0;
                    if (s_repeat) begin
                        n_left = 8'd0;
                    end else begin
                        n_left = s_left - 8'd1;
                    end
                    if (n_left == 8'd0) begin
                        n_expect_header = 1'b1;
                    end
                    n_done = s_done + run_clip[CNT_W-1:0];
                    if (run_end) begin
                        n_finished = 1'b1;
                    end
                end
            end
        end
    end

    // Result register: load whenever it is not held by a stalled receiver.
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (!o_stall) begin
            n_out_valid      = emit;
            n_out.color      = pixel_color(bpp_eff, pixel_bytes);
            n_out.run_length = run_clip[7:0];
            n_out.image_end  = run_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp           <= BPP_RESET;
            r_pixel_total   <= TOTAL_RESET;
            r_expect_header <= 1'b1;
            r_repeat        <= 1'b0;
            r_left          <= 8'd0;
            r_bpos          <= 2'd0;
            r_gather        <= 24'd0;
            r_done          <= '0;
            r_finished      <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_expect_header <= n_expect_header;
            r_repeat        <= n_repeat;
            r_left          <= n_left;
            r_bpos          <= n_bpos;
            r_gather        <= n_gather;
            r_done          <= n_done;
            r_finished      <= n_finished;
            r_out_valid     <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_BYTES_PER_PIXEL: r_bpp         <= i_cfg_data[2:0];
                    CFG_PIXEL_TOTAL:     r_pixel_total <= i_cfg_data;
                    default:             r_bpp         <= r_bpp;
                endcase
            end
        end
    end

    // Payload holds no reset.
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // A stall is only raised by a full result register, which then stays full.
    a_stall_keeps_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> o_valid)
        else $error("result register emptied while stalled");

    // The run that closes the image marks it finished.
    a_end_sets_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && run_end) |=> r_finished)
        else $error("image_end run did not finish the image");

    // Between header and last pixel of a packet there are always pixels left.
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_expect_header && !r_finished) |-> (r_left != 8'd0))
        else $error("packet has no pixels left outside header phase");

    // Emitted runs are never empty.
    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (o_data.run_length != 8'd0))
        else $error("empty run emitted");

endmodule
